// File: sv/pod_pkg.sv
// Shared types and constants for the pulse output / delayed input port block.
// Used by the channel interfaces, the output stage and the top level.
package pod_pkg;

  localparam int PORT_COUNT = 32;
  localparam int PORT_W     = 5;
  localparam int TICK_W     = 32;
  localparam int DUR_W      = 16;
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [PORT_W-1:0] LAST_PORT = PORT_W'(PORT_COUNT - 1);

  typedef enum logic [1:0] {
    OP_SWITCH = 2'd0,
    OP_SCAN   = 2'd1,
    OP_TIMING = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    EV_DRIVE  = 2'd0,
    EV_PULSE  = 2'd1,
    EV_SENSOR = 2'd2
  } event_kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_OUTPUT_MASK = 2'd0,
    REG_INPUT_MASK  = 2'd1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    event_kind_t        kind;
    logic [PORT_W-1:0]  port;
    logic               level;
  } event_t;

  // Request from the sequencer to the output stage
  typedef struct packed {
    logic   push;
    logic   flush;
    event_t ev;
  } emit_req_t;

  // Status from the output stage back to the sequencer
  typedef struct packed {
    logic room;
    logic pend_valid;
  } emit_resp_t;

endpackage

// File: sv/pod_if.sv
// Channel interfaces: command items, result events and register writes.
// Depends on pod_pkg for widths.
interface pod_item_if import pod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [1:0]            operation;
  logic [PORT_W-1:0]     port;
  logic                  switch_on;
  logic [PORT_COUNT-1:0] pin_levels;
  logic [DUR_W-1:0]      pulse_length;
  logic [DUR_W-1:0]      hold_delay;

  modport source (output valid, operation, port, switch_on, pin_levels, pulse_length,
                  hold_delay, input ready);
  modport sink (input valid, operation, port, switch_on, pin_levels, pulse_length,
                hold_delay, output ready);
endinterface

interface pod_result_if import pod_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [1:0]        event_kind;
  logic [PORT_W-1:0] event_port;
  logic              level;
  logic              last;

  modport source (output valid, event_kind, event_port, level, last, input ready);
  modport sink (input valid, event_kind, event_port, level, last, output ready);
endinterface

interface pod_cfg_if import pod_pkg::*; ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// File: sv/pod_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read.
// Each entry carries a valid bit so that an unwritten entry reads as zero.
module pod_ram #(
  parameter int DEPTH = 32,
  parameter int WIDTH = 32
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [DEPTH-1:0] written;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Track which entries hold data since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      written <= '0;
    end else if (we) begin
      written[waddr] <= 1'b1;
    end
  end

  // Registered read, zero for entries never written
  always_ff @(posedge clk) begin
    rdata <= written[raddr] ? mem[raddr] : '0;
  end

endmodule

// File: sv/pod_out_stage.sv
// Result output stage: one pending event and one output register.
// The pending event goes out with last set only when the item is flushed.
module pod_out_stage import pod_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  input  emit_req_t     req,
  output emit_resp_t    resp,
  pod_result_if.source  result
);

  logic   out_valid;
  event_t out_ev;
  logic   out_last;
  logic   pend_valid;
  event_t pend_ev;
  logic   out_free;
  logic   room;
  logic   load_out;

  assign out_free = !out_valid || result.ready;
  assign room     = !pend_valid || out_free;
  assign load_out = pend_valid && out_free && (req.push || req.flush);

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_ev   <= pend_ev;
      out_last <= req.flush;
    end
  end

  // Pending event: hold until a later event or the end of the item
  always_ff @(posedge clk) begin
    if (rst) begin
      pend_valid <= 1'b0;
    end else if (req.push && room) begin
      pend_valid <= 1'b1;
    end else if (req.flush && out_free) begin
      pend_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req.push && room) begin
      pend_ev <= req.ev;
    end
  end

  assign resp.room       = room;
  assign resp.pend_valid = pend_valid;

  assign result.valid      = out_valid;
  assign result.event_kind = out_ev.kind;
  assign result.event_port = out_ev.port;
  assign result.level      = out_ev.level;
  assign result.last       = out_last;

endmodule

// File: sv/pulse_output_delayed_input_ports.sv
// 32-port I/O block with pulsed outputs and off-delayed inputs. A switch item gives one drive
// event and a timing load gives none. A scan item has a transfer step, a visit to each port in
// turn and a flush: the per-port timer and timing memories are read one port per cycle through
// their single read ports unless the result consumer stalls, and each port's state is updated
// as it is visited. Switch and scan items are held up while the result consumer stalls. Events
// of one item come out in ascending port order, the final one marked last. A new item is taken
// once the previous item's events have left the pending stage; the output register may still
// hold one.
module pulse_output_delayed_input_ports import pod_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  pod_item_if.sink     item,
  pod_result_if.source result,
  pod_cfg_if.sink      cfg
);

  state_t                state;
  state_t                state_next;
  logic [PORT_W-1:0]     idx;
  logic [TICK_W-1:0]     tick_now;
  logic [PORT_COUNT-1:0] pins;
  logic [PORT_COUNT-1:0] output_mask;
  logic [PORT_COUNT-1:0] input_mask;
  logic [PORT_COUNT-1:0] port_active;
  logic [PORT_COUNT-1:0] last_reported;

  logic                  item_acc;
  logic                  in_range;
  emit_req_t             req;
  emit_resp_t            resp;

  // Memory ports
  logic                  tmr_we;
  logic [PORT_W-1:0]     tmr_waddr;
  logic [TICK_W-1:0]     tmr_rdata;
  logic                  tim_we;
  logic [2*DUR_W-1:0]    tim_rdata;
  logic [PORT_W-1:0]     rd_addr;

  // Flag updates
  logic                  act_set;
  logic                  act_clr;
  logic [PORT_W-1:0]     act_addr;
  logic                  lr_we;
  logic                  advance;

  // Visit of one port during a scan
  logic [DUR_W-1:0]      pulse;
  logic [DUR_W-1:0]      delay;
  logic [TICK_W-1:0]     elapsed;
  logic                  val;
  logic                  act;
  logic                  scan_emit;
  logic                  scan_set;
  logic                  scan_clr;
  logic                  scan_tmr;
  event_t                scan_ev;

  assign item_acc = item.valid && item.ready;
  assign in_range = {1'b0, item.port} < (PORT_W + 1)'(PORT_COUNT);
  assign item.ready = (state == ST_IDLE);
  assign cfg.ready  = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      output_mask <= '0;
      input_mask  <= '0;
    end else if (cfg.valid) begin
      case (cfg_reg_t'(cfg.index))
        REG_OUTPUT_MASK: output_mask <= cfg.data[PORT_COUNT-1:0];
        REG_INPUT_MASK:  input_mask  <= cfg.data[PORT_COUNT-1:0];
        default: ;
      endcase
    end
  end

  // Per-port timer start and timing tables
  pod_ram #(.DEPTH(PORT_COUNT), .WIDTH(TICK_W)) u_timer_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (tmr_we),
    .waddr (tmr_waddr),
    .wdata (tick_now),
    .raddr (rd_addr),
    .rdata (tmr_rdata)
  );

  pod_ram #(.DEPTH(PORT_COUNT), .WIDTH(2 * DUR_W)) u_timing_mem (
    .clk   (clk),
    .rst   (rst),
    .we    (tim_we),
    .waddr (item.port),
    .wdata ({item.pulse_length, item.hold_delay}),
    .raddr (rd_addr),
    .rdata (tim_rdata)
  );

  pod_out_stage u_out (
    .clk    (clk),
    .rst    (rst),
    .req    (req),
    .resp   (resp),
    .result (result)
  );

  // Decide what the visited port does
  always_comb begin
    pulse     = tim_rdata[2*DUR_W-1:DUR_W];
    delay     = tim_rdata[DUR_W-1:0];
    elapsed   = tick_now - tmr_rdata;
    val       = pins[idx];
    act       = port_active[idx];
    scan_emit = 1'b0;
    scan_set  = 1'b0;
    scan_clr  = 1'b0;
    scan_tmr  = 1'b0;
    scan_ev   = '{kind: EV_SENSOR, port: idx, level: val};
    if (output_mask[idx]) begin
      if (pulse != '0 && act && elapsed >= {{(TICK_W-DUR_W){1'b0}}, pulse}) begin
        scan_clr  = 1'b1;
        scan_emit = 1'b1;
        scan_ev   = '{kind: EV_PULSE, port: idx, level: 1'b0};
      end
    end else if (input_mask[idx]) begin
      if (delay == '0) begin
        scan_emit = (last_reported[idx] != val);
      end else if (val) begin
        scan_tmr  = 1'b1;
        scan_set  = !act;
        scan_emit = !act;
      end else if (act && elapsed >= {{(TICK_W-DUR_W){1'b0}}, delay}) begin
        scan_clr  = 1'b1;
        scan_emit = 1'b1;
      end
    end
  end

  // Sequencer: next state, memory ports and flag updates
  always_comb begin
    state_next = state;
    req        = '0;
    advance    = 1'b0;
    tmr_we     = 1'b0;
    tmr_waddr  = idx;
    tim_we     = 1'b0;
    rd_addr    = idx;
    act_set    = 1'b0;
    act_clr    = 1'b0;
    act_addr   = idx;
    lr_we      = 1'b0;
    case (state)
      ST_IDLE: begin
        rd_addr = '0;
        if (item_acc) begin
          case (op_t'(item.operation))
            OP_SWITCH: begin
              req.push   = 1'b1;
              req.ev     = '{kind: EV_DRIVE, port: item.port, level: item.switch_on};
              tmr_we     = item.switch_on && in_range;
              tmr_waddr  = item.port;
              act_set    = item.switch_on && in_range;
              act_addr   = item.port;
              state_next = ST_FLUSH;
            end
            OP_SCAN:   state_next = ST_SCAN;
            OP_TIMING: tim_we = in_range;
            default: ;
          endcase
        end
      end
      ST_SCAN: begin
        req.push = scan_emit;
        req.ev   = scan_ev;
        advance  = !scan_emit || resp.room;
        rd_addr  = advance ? idx + 1'b1 : idx;
        if (advance) begin
          tmr_we  = scan_tmr;
          act_set = scan_set;
          act_clr = scan_clr;
          lr_we   = scan_emit && (scan_ev.kind == EV_SENSOR);
          if (idx == LAST_PORT) begin
            state_next = ST_FLUSH;
          end
        end
      end
      ST_FLUSH: begin
        req.flush = 1'b1;
        if (resp.room) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Port walk counter
  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= '0;
    end else if (state == ST_IDLE) begin
      idx <= '0;
    end else if (state == ST_SCAN && advance) begin
      idx <= idx + 1'b1;
    end
  end

  // Advance the tick and capture pin levels on a scan transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      tick_now <= '0;
    end else if (item_acc && op_t'(item.operation) == OP_SCAN) begin
      tick_now <= tick_now + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc && op_t'(item.operation) == OP_SCAN) begin
      pins <= item.pin_levels;
    end
  end

  // Active and last-reported flags
  always_ff @(posedge clk) begin
    if (rst) begin
      port_active   <= '0;
      last_reported <= '0;
    end else begin
      if (act_set) begin
        port_active[act_addr] <= 1'b1;
      end else if (act_clr) begin
        port_active[act_addr] <= 1'b0;
      end
      if (lr_we) begin
        last_reported[idx] <= val;
      end
    end
  end

  // Checks
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |-> !resp.pend_valid)
    else $error("pending event left over at idle");

  a_scan_starts_at_zero: assert property (@(posedge clk) disable iff (rst)
    (item_acc && op_t'(item.operation) == OP_SCAN) |=> (state == ST_SCAN && idx == '0))
    else $error("scan did not start at port zero");

  a_tick_advance: assert property (@(posedge clk) disable iff (rst)
    (item_acc && op_t'(item.operation) == OP_SCAN) |=> tick_now == $past(tick_now) + 1'b1)
    else $error("tick counter did not advance on scan");

  a_stall_holds_port: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && !advance) |=> (state == ST_SCAN && idx == $past(idx)))
    else $error("port walk moved while stalled");

endmodule
